>>> rtl/qs3d_pkg.sv
`default_nettype none

package qs3d_pkg;

  localparam int CODE_BITS_DEF     = 9;
  localparam int FRACTION_BITS_DEF = 14;

  // 1.414214 and 0.707107 in Q32; bias 2^33 folded in so the add stays unsigned
  localparam logic [32:0] SCALE_Q32 = 33'd6074002880;
  localparam logic [33:0] BIAS_ADJ  = 34'd5552933152;

  localparam int OUT_W = 34;

  typedef struct packed {
    logic [1:0] largest_index;
    logic       largest_negative;
    logic       root_clamped;
  } qs3d_ctl_t;

  function automatic logic [15:0] sat16(input logic signed [OUT_W-1:0] x);
    logic [15:0] res;
    if (x > OUT_W'(32767)) begin
      res = 16'h7fff;
    end else if (x < -OUT_W'(32768)) begin
      res = 16'h8000;
    end else begin
      res = x[15:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/qs3d_front.sv
`default_nettype none

module qs3d_front import qs3d_pkg::*; #(
  parameter int CODE_BITS     = CODE_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  localparam int CW = FRACTION_BITS + 2,
  localparam int DW = 2 * FRACTION_BITS + 2
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             in_index,
  input  wire logic                   in_neg,
  input  wire logic [3*CODE_BITS-1:0] in_codes,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [3*CW-1:0]             out_comps,
  output qs3d_ctl_t                   out_ctl,
  output logic [DW-1:0]               out_d
);

  localparam int PW   = CODE_BITS + 33;
  localparam int SH   = 32 - FRACTION_BITS;
  localparam int UW   = 36;
  localparam int MW   = FRACTION_BITS + 1;
  localparam int QW   = 2 * MW;
  localparam int SUMW = QW + 2;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  qs3d_ctl_t ctl1_r, ctl2_r, ctl3_r, ctl4_r;

  logic [PW-1:0]        prod_r [3];
  logic signed [CW-1:0] comp2_r [3];
  logic [MW-1:0]        mag2_r [3];
  logic signed [CW-1:0] comp3_r [3];
  logic [QW-1:0]        sq3_r [3];
  logic signed [CW-1:0] comp4_r [3];
  logic [DW-1:0]        d4_r;

  logic signed [CW-1:0] comp_nxt [3];
  logic [MW-1:0]        mag_nxt [3];
  logic [SUMW-1:0]      sum;
  logic [SUMW-1:0]      one;
  logic                 clamp_nxt;
  logic [DW-1:0]        d_nxt;

  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [UW-1:0]        u;
      logic [UW-1:0]        r;
      logic [UW-1:0]        c;
      logic signed [CW-1:0] cs;
      logic signed [CW-1:0] cn;
      u  = UW'(prod_r[k] >> CODE_BITS) + UW'(BIAS_ADJ) + (UW'(1) << (SH - 1));
      r  = u >> SH;
      c  = r - (UW'(1) << (33 - SH));
      cs = signed'(c[CW-1:0]);
      cn = -cs;
      comp_nxt[k] = cs;
      mag_nxt[k]  = cs[CW-1] ? cn[MW-1:0] : cs[MW-1:0];
    end
  end

  assign sum       = SUMW'(sq3_r[0]) + SUMW'(sq3_r[1]) + SUMW'(sq3_r[2]);
  assign one       = SUMW'(1) << (2 * FRACTION_BITS);
  assign clamp_nxt = sum > one;
  assign d_nxt     = clamp_nxt ? '0 : DW'(one - sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      for (int k = 0; k < 3; k++) begin
        prod_r[k] <= PW'(in_codes[k*CODE_BITS +: CODE_BITS]) * PW'(SCALE_Q32);
      end
      ctl1_r.largest_index    <= in_index;
      ctl1_r.largest_negative <= in_neg;
      ctl1_r.root_clamped     <= 1'b0;
    end
    if (rdy2 && v1_r) begin
      comp2_r <= comp_nxt;
      mag2_r  <= mag_nxt;
      ctl2_r  <= ctl1_r;
    end
    if (rdy3 && v2_r) begin
      for (int k = 0; k < 3; k++) begin
        sq3_r[k] <= QW'(mag2_r[k]) * QW'(mag2_r[k]);
      end
      comp3_r <= comp2_r;
      ctl3_r  <= ctl2_r;
    end
    if (rdy4 && v3_r) begin
      comp4_r <= comp3_r;
      d4_r    <= d_nxt;
      ctl4_r  <= '{largest_index:    ctl3_r.largest_index,
                   largest_negative: ctl3_r.largest_negative,
                   root_clamped:     clamp_nxt};
    end
  end

  assign out_valid = v4_r;
  assign out_comps = {comp4_r[2], comp4_r[1], comp4_r[0]};
  assign out_ctl   = ctl4_r;
  assign out_d     = d4_r;

endmodule

`default_nettype wire

>>> rtl/qs3d_root_cell.sv
`default_nettype none

module qs3d_root_cell import qs3d_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int SIDE_W        = 1,
  localparam int RW = FRACTION_BITS + 4,
  localparam int QW = FRACTION_BITS + 1,
  localparam int DW = 2 * FRACTION_BITS + 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [RW-1:0]     in_rem,
  input  wire logic [QW-1:0]     in_q,
  input  wire logic [DW-1:0]     in_rad,
  input  wire logic [SIDE_W-1:0] in_side,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [RW-1:0]          out_rem,
  output logic [QW-1:0]          out_q,
  output logic [DW-1:0]          out_rad,
  output logic [SIDE_W-1:0]      out_side
);

  logic              valid_r;
  logic [RW-1:0]     rem_r;
  logic [QW-1:0]     q_r;
  logic [DW-1:0]     rad_r;
  logic [SIDE_W-1:0] side_r;

  logic [RW-1:0] rem_sh;
  logic [RW-1:0] trial;
  logic          fits;
  logic [RW-1:0] rem_nxt;
  logic [QW-1:0] q_nxt;

  // one result bit per cell: bring down two radicand bits, try 4q+1
  assign rem_sh   = {in_rem[RW-3:0], in_rad[DW-1:DW-2]};
  assign trial    = RW'({in_q, 2'b01});
  assign fits     = rem_sh >= trial;
  assign rem_nxt  = fits ? rem_sh - trial : rem_sh;
  assign q_nxt    = {in_q[QW-2:0], fits};
  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      rad_r  <= {in_rad[DW-3:0], 2'b00};
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_q     = q_r;
  assign out_rad   = rad_r;
  assign out_side  = side_r;

endmodule

`default_nettype wire

>>> rtl/quat_smallest_three_decode.sv
`default_nettype none

// Smallest-three quaternion decoder. in_tdata carries the three stored codes,
// in_tuser the dropped component's index and sign; out_tdata returns w, x, y, z
// as signed 16-bit fixed point (1.0 = 2^FRACTION_BITS) and out_tuser flags a
// root that was clamped to zero. One beat is accepted per cycle unless the
// output stalls. The pipeline has four front stages (code scaling multiply,
// rounding, squaring, sum and compare), one square root cell per result bit
// (FRACTION_BITS + 1 cells), and the output register.

module quat_smallest_three_decode import qs3d_pkg::*; #(
  parameter int CODE_BITS     = CODE_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  localparam int IN_TDATA_W = ((3 * CODE_BITS + 7) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // code_first, code_second, code_third
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  // largest_index[1:0], largest_negative
  input  wire logic [2:0]            in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // comp_w, comp_x, comp_y, comp_z
  output logic [63:0]                out_tdata,
  // root_clamped
  output logic [0:0]                 out_tuser
);

  localparam int CW     = FRACTION_BITS + 2;
  localparam int DW     = 2 * FRACTION_BITS + 2;
  localparam int RW     = FRACTION_BITS + 4;
  localparam int QW     = FRACTION_BITS + 1;
  localparam int RTW    = FRACTION_BITS + 2;
  localparam int NB     = FRACTION_BITS + 1;
  localparam int CTLW   = $bits(qs3d_ctl_t);
  localparam int SIDE_W = 3 * CW + CTLW;

  logic            f_valid;
  logic [3*CW-1:0] f_comps;
  qs3d_ctl_t       f_ctl;
  logic [DW-1:0]   f_d;

  logic              cv    [NB+1];
  logic              crdy  [NB+1];
  logic [RW-1:0]     crem  [NB+1];
  logic [QW-1:0]     cq    [NB+1];
  logic [DW-1:0]     crad  [NB+1];
  logic [SIDE_W-1:0] cside [NB+1];

  qs3d_front #(
    .CODE_BITS     (CODE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_index  (in_tuser[1:0]),
    .in_neg    (in_tuser[2]),
    .in_codes  (in_tdata[3*CODE_BITS-1:0]),
    .out_valid (f_valid),
    .out_ready (crdy[0]),
    .out_comps (f_comps),
    .out_ctl   (f_ctl),
    .out_d     (f_d)
  );

  assign cv[0]    = f_valid;
  assign crem[0]  = '0;
  assign cq[0]    = '0;
  assign crad[0]  = f_d;
  assign cside[0] = {f_ctl, f_comps};

  for (genvar g = 0; g < NB; g++) begin : g_cell
    qs3d_root_cell #(
      .FRACTION_BITS (FRACTION_BITS),
      .SIDE_W        (SIDE_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cv[g]),
      .in_ready  (crdy[g]),
      .in_rem    (crem[g]),
      .in_q      (cq[g]),
      .in_rad    (crad[g]),
      .in_side   (cside[g]),
      .out_valid (cv[g+1]),
      .out_ready (crdy[g+1]),
      .out_rem   (crem[g+1]),
      .out_q     (cq[g+1]),
      .out_rad   (crad[g+1]),
      .out_side  (cside[g+1])
    );
  end

  logic                 out_valid_r;
  logic [15:0]          out_comp_r [4];
  logic                 out_clamp_r;
  logic                 last_ready;
  qs3d_ctl_t            last_ctl;
  logic [RTW-1:0]       root_u;
  logic signed [CW-1:0] last_comp [3];
  logic [15:0]          out_comp_nxt [4];

  assign last_ready = !out_valid_r || out_tready;
  assign crdy[NB]   = last_ready;
  assign last_ctl   = qs3d_ctl_t'(cside[NB][SIDE_W-1 -: CTLW]);

  // round to nearest: bump when the remainder exceeds the floor root
  assign root_u = RTW'(cq[NB]) + RTW'(crem[NB] > RW'(cq[NB]));

  always_comb begin
    logic signed [OUT_W-1:0] root_s;
    logic signed [OUT_W-1:0] val;
    int slot;
    for (int k = 0; k < 3; k++) begin
      last_comp[k] = signed'(cside[NB][k*CW +: CW]);
    end
    root_s = signed'(OUT_W'(root_u));
    if (last_ctl.root_clamped) begin
      root_s = '0;
    end else if (last_ctl.largest_negative) begin
      root_s = -root_s;
    end
    for (int i = 0; i < 4; i++) begin
      slot = (i < int'(last_ctl.largest_index)) ? i : i - 1;
      if (i == int'(last_ctl.largest_index)) begin
        val = root_s;
      end else begin
        val = OUT_W'(last_comp[slot[1:0]]);
      end
      out_comp_nxt[i] = sat16(val);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (last_ready) begin
      out_valid_r <= cv[NB];
    end
  end

  always_ff @(posedge clk) begin
    if (last_ready && cv[NB]) begin
      out_comp_r  <= out_comp_nxt;
      out_clamp_r <= last_ctl.root_clamped;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_comp_r[3], out_comp_r[2], out_comp_r[1], out_comp_r[0]};
  assign out_tuser  = out_clamp_r;

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cv[NB] |-> crem[NB] <= RW'({cq[NB], 1'b0}))
    else $error("root remainder above twice the root");

  a_clamp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cv[NB] && last_ctl.root_clamped |-> cq[NB] == '0)
    else $error("clamped beat reached the end with a nonzero root");

  a_rad_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cv[NB] |-> crad[NB] == '0)
    else $error("radicand bits left after the last cell");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC        = 14;
  localparam int Q32_SHIFT   = 32 - FRAC;
  localparam int LATENCY     = FRAC + 6;
  localparam int TAIL        = 2 * LATENCY;
  localparam int HOLD_OFF    = 100;
  localparam int RANDOM_QUATS = 1900;

  localparam logic [63:0] CODE_SCALE  = 64'd6074002880;
  localparam logic [63:0] CODE_OFFSET = 64'd3037001440;
  localparam logic [63:0] Q32_BIAS    = 64'd1 << 33;
  localparam logic [63:0] ROUND_HALF  = 64'd1 << (Q32_SHIFT - 1);
  localparam logic [63:0] UNIT_SQ     = 64'd1 << (2 * FRAC);

  localparam logic [8:0] CODE_MIN = 9'd0;
  localparam logic [8:0] CODE_MID = 9'd256;
  localparam logic [8:0] CODE_MAX = 9'd511;

  // decoded values of the extreme codes, 1.0 = 16384
  localparam int ONE_Q     = 16384;
  localparam int CORNER_LO = -11585;
  localparam int CORNER_HI = 11540;

  typedef enum logic [1:0] {AXIS_W, AXIS_X, AXIS_Y, AXIS_Z} axis_t;

  typedef struct packed {
    axis_t      idx;
    logic       neg;
    logic [8:0] c0;
    logic [8:0] c1;
    logic [8:0] c2;
  } beat_t;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               clamped;
  } quat_t;

  typedef struct packed {
    beat_t b;
    bit    known;
    quat_t want;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic [0:0]  out_tuser;

  quat_t pending_quats [$];
  row_t  rows [$];
  int    mismatches = 0;
  int    quats_seen = 0;
  bit    calm = 1'b0;

  quat_smallest_three_decode dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

  // code -> Q32 -> FRAC fraction bits, rounded half up
  function automatic logic signed [63:0] code_to_fixed(input logic [8:0] code);
    logic [63:0] q32;
    q32 = ((64'(code) * CODE_SCALE) >> 9) + Q32_BIAS - CODE_OFFSET;
    return $signed((q32 + ROUND_HALF) >> Q32_SHIFT) - $signed(Q32_BIAS >> Q32_SHIFT);
  endfunction

  function automatic logic [63:0] nearest_root(input logic [63:0] d);
    logic [63:0] r;
    logic [63:0] trial;
    r = '0;
    for (int i = 15; i >= 0; i--) begin
      trial = r | (64'd1 << i);
      if (trial * trial <= d) r = trial;
    end
    if (d - r * r > r) r = r + 1;
    return r;
  endfunction

  function automatic logic signed [15:0] clip16(input logic signed [63:0] v);
    if (v > 64'sd32767) return 16'sh7fff;
    if (v < -64'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic quat_t decode_quat(input beat_t b);
    logic signed [63:0] comp [4];
    logic [8:0]         codes [3];
    logic [63:0]        sq_sum;
    logic [63:0]        root;
    int                 k;
    quat_t              q;
    codes[0] = b.c0;
    codes[1] = b.c1;
    codes[2] = b.c2;
    k = 0;
    sq_sum = '0;
    q.clamped = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (i == int'(b.idx)) begin
        comp[i] = '0;
      end else begin
        comp[i] = code_to_fixed(codes[k]);
        sq_sum += comp[i] * comp[i];
        k++;
      end
    end
    if (sq_sum > UNIT_SQ) begin
      q.clamped = 1'b1;
    end else begin
      root = nearest_root(UNIT_SQ - sq_sum);
      comp[b.idx] = b.neg ? -$signed(root) : $signed(root);
    end
    q.w = clip16(comp[0]);
    q.x = clip16(comp[1]);
    q.y = clip16(comp[2]);
    q.z = clip16(comp[3]);
    return q;
  endfunction

  task automatic add_row(input axis_t a, input bit neg, input logic [8:0] c0, c1, c2,
                         input bit known, input int w, x, y, z, input bit cl);
    row_t r;
    r.b = '{idx: a, neg: neg, c0: c0, c1: c1, c2: c2};
    r.known = known;
    r.want = '{w: 16'(w), x: 16'(x), y: 16'(y), z: 16'(z), clamped: cl};
    rows.push_back(r);
  endtask

  task automatic send_beat(input beat_t b, input bit known, input quat_t want);
    while (!calm && $urandom_range(99) < 29) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, b.c2, b.c1, b.c0};
    in_tuser  <= {b.neg, b.idx};
    do @(posedge clk); while (in_tready !== 1'b1);
    pending_quats.push_back(known ? want : decode_quat(b));
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic signed [15:0] want_v, got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  initial begin : drive
    beat_t      b;
    logic [8:0] pick [3];
    int         mode;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;

    // all codes mid: the dropped axis rebuilds to exactly +-1.0
    add_row(AXIS_W, 0, CODE_MID, CODE_MID, CODE_MID, 1, ONE_Q, 0, 0, 0, 0);
    add_row(AXIS_W, 1, CODE_MID, CODE_MID, CODE_MID, 1, -ONE_Q, 0, 0, 0, 0);
    add_row(AXIS_X, 0, CODE_MID, CODE_MID, CODE_MID, 1, 0, ONE_Q, 0, 0, 0);
    add_row(AXIS_X, 1, CODE_MID, CODE_MID, CODE_MID, 1, 0, -ONE_Q, 0, 0, 0);
    add_row(AXIS_Y, 0, CODE_MID, CODE_MID, CODE_MID, 1, 0, 0, ONE_Q, 0, 0);
    add_row(AXIS_Y, 1, CODE_MID, CODE_MID, CODE_MID, 1, 0, 0, -ONE_Q, 0, 0);
    add_row(AXIS_Z, 0, CODE_MID, CODE_MID, CODE_MID, 1, 0, 0, 0, ONE_Q, 0);
    add_row(AXIS_Z, 1, CODE_MID, CODE_MID, CODE_MID, 1, 0, 0, 0, -ONE_Q, 0);
    // sum of squares above one: root clamped, sign ignored; the last row stays under one
    add_row(AXIS_W, 1, CODE_MIN, CODE_MIN, CODE_MIN, 1, 0, CORNER_LO, CORNER_LO, CORNER_LO, 1);
    add_row(AXIS_X, 1, CODE_MIN, CODE_MIN, CODE_MIN, 1, CORNER_LO, 0, CORNER_LO, CORNER_LO, 1);
    add_row(AXIS_Y, 0, CODE_MIN, CODE_MIN, CODE_MIN, 1, CORNER_LO, CORNER_LO, 0, CORNER_LO, 1);
    add_row(AXIS_Z, 1, CODE_MIN, CODE_MIN, CODE_MIN, 1, CORNER_LO, CORNER_LO, CORNER_LO, 0, 1);
    add_row(AXIS_W, 0, CODE_MAX, CODE_MAX, CODE_MAX, 1, 0, CORNER_HI, CORNER_HI, CORNER_HI, 1);
    add_row(AXIS_Z, 1, CODE_MAX, CODE_MAX, CODE_MAX, 1, CORNER_HI, CORNER_HI, CORNER_HI, 0, 1);
    add_row(AXIS_X, 1, CODE_MIN, CODE_MAX, CODE_MID, 0, 0, 0, 0, 0, 0);
    // just under one: tiny root; the rows after it mix codes
    add_row(AXIS_Y, 0, CODE_MIN, CODE_MIN, CODE_MID, 0, 0, 0, 0, 0, 0);
    add_row(AXIS_W, 1, CODE_MAX, CODE_MID, CODE_MIN, 0, 0, 0, 0, 0, 0);
    add_row(AXIS_Z, 0, CODE_MAX, CODE_MIN, CODE_MAX, 0, 0, 0, 0, 0, 0);
    add_row(AXIS_X, 0, 9'd1, 9'd510, 9'd255, 0, 0, 0, 0, 0, 0);
    add_row(AXIS_Y, 1, 9'd257, 9'd128, 9'd384, 0, 0, 0, 0, 0, 0);
    add_row(AXIS_W, 0, 9'h155, 9'h0aa, 9'h1ff, 0, 0, 0, 0, 0, 0);

    wait (rst_n === 1'b1);
    @(negedge clk);
    foreach (rows[i]) send_beat(rows[i].b, rows[i].known, rows[i].want);

    for (int n = 0; n < RANDOM_QUATS; n++) begin
      calm = (n >= 600 && n < 900);
      if (n == 1200) begin
        in_tvalid <= 1'b0;
        while (pending_quats.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      b.idx = axis_t'($urandom_range(3));
      b.neg = 1'($urandom_range(1));
      for (int j = 0; j < 3; j++) begin
        mode = $urandom_range(99);
        if (mode < 60) begin
          pick[j] = 9'($urandom_range(511));
        end else if (mode < 85) begin
          pick[j] = 9'($urandom_range(346, 166));
        end else begin
          case ($urandom_range(3))
            0: pick[j] = CODE_MIN;
            1: pick[j] = CODE_MAX;
            2: pick[j] = CODE_MID;
            default: pick[j] = $urandom_range(1) ? CODE_MID + 9'd1 : CODE_MID - 9'd1;
          endcase
        end
      end
      b.c0 = pick[0];
      b.c1 = pick[1];
      b.c2 = pick[2];
      send_beat(b, 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    while (pending_quats.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : sink
    bit held;
    held = 1'b0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (!held && quats_seen >= 400) begin
        // long back-pressure: pipeline fills and in_tready must drop
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_OFF) @(negedge clk);
      end else begin
        out_tready <= calm || ($urandom_range(99) >= 29);
      end
    end
  end

  always @(posedge clk) begin : monitor
    quat_t got;
    quat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.w = out_tdata[15:0];
      got.x = out_tdata[31:16];
      got.y = out_tdata[47:32];
      got.z = out_tdata[63:48];
      got.clamped = out_tuser[0];
      quats_seen++;
      if (pending_quats.size() == 0) begin
        $error("result beat with no pending decode");
        mismatches++;
      end else begin
        want = pending_quats.pop_front();
        check_field("comp_w", want.w, got.w);
        check_field("comp_x", want.x, got.x);
        check_field("comp_y", want.y, got.y);
        check_field("comp_z", want.z, got.z);
        check_field("root_clamped", want.clamped, got.clamped);
      end
    end
  end

endmodule

>>> sim.f
rtl/qs3d_pkg.sv
rtl/qs3d_front.sv
rtl/qs3d_root_cell.sv
rtl/quat_smallest_three_decode.sv
tb/sv/tb_top.sv
